[rtl/tnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types and constants for the tick / nanosecond converter.
// ----------------------------------------------------------------------------
package tnc_pkg;

    localparam logic [31:0] NS_PER_SEC  = 32'd1000000000;
    localparam logic [63:0] NS_ROUND_UP = 64'd999999999;

    localparam logic       CMD_TICKS_TO_NS = 1'b0;
    localparam logic       CMD_NS_TO_TICKS = 1'b1;

    localparam logic       REG_TICK_RATE = 1'b0;
    localparam logic       REG_MONO_EN   = 1'b1;

    localparam int DIV1_STEPS = 64;
    localparam int DIV2_STEPS = 32;

    // per-transaction sideband carried along the pipeline
    typedef struct packed {
        logic        cmd;
        logic        ok;
        logic        nz;
        logic [31:0] rate;
        logic [63:0] whole;
        logic        wovf;
    } side_t;

    // state of one divider step
    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] num;
        logic [63:0] quo;
        logic [31:0] dvs;
        side_t       side;
    } cell_t;

endpackage

[rtl/tnc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnc_cell
// One restoring-division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module tnc_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  tnc_pkg::cell_t in_d,
    output logic          out_v,
    output tnc_pkg::cell_t out_d
);
    import tnc_pkg::*;

    logic        valid_reg;
    cell_t       data_reg;
    cell_t       data_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    always_comb
    begin
        trial     = {in_d.rem, in_d.num[63]};
        diff      = trial - {1'b0, in_d.dvs};
        qbit      = (trial >= {1'b0, in_d.dvs});
        data_next = in_d;
        data_next.rem = qbit ? diff[31:0] : trial[31:0];
        data_next.num = {in_d.num[62:0], 1'b0};
        data_next.quo = {in_d.quo[62:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_v = valid_reg;
    assign out_d = data_reg;

endmodule

[rtl/timer_tick_ns_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_tick_ns_converter_unit
// Converts counter ticks to ns or ns to ticks at the configured tick rate.
// ----------------------------------------------------------------------------
// Pipeline: 64 divider cells, multiply, combine, 32 divider cells, output
// register. Throughput: one transaction per cycle unless the output stalls;
// the divider cell chains set depth.
// Reset clears all valid bits and both configuration registers.
// A stall on a valid output holds the whole pipeline.
module timer_tick_ns_converter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [63:0] operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [63:0] value,
    output logic        overflow
);
    import tnc_pkg::*;

    logic [31:0] rate_reg;
    logic        mono_reg;
    logic        adv;

    cell_t a_in;
    cell_t a_d [0:DIV1_STEPS];
    logic  a_v [0:DIV1_STEPS];
    cell_t b_d [0:DIV2_STEPS];
    logic  b_v [0:DIV2_STEPS];

    logic        m_v_reg;
    side_t       m_side_reg;
    logic [63:0] m_plo_reg;
    logic [63:0] m_phi_reg;
    logic [63:0] m_pr_reg;
    logic [31:0] mult;

    logic        c_v_reg;
    logic [95:0] wsum;
    logic [63:0] rsum;
    cell_t       c_next;
    cell_t       c_d_reg;

    logic [64:0] fsum;
    logic [63:0] fres;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [63:0] value_reg;
    logic        overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 32'd0;
            mono_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TICK_RATE: rate_reg <= wr_data;
                REG_MONO_EN:   mono_reg <= wr_data[0];
                default:       rate_reg <= rate_reg;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // first divide: operand by rate (ticks to ns) or by 1e9 (ns to ticks)
    always_comb
    begin
        a_in            = '0;
        a_in.rem        = 32'd0;
        a_in.num        = operand;
        a_in.quo        = 64'd0;
        a_in.dvs        = (command == CMD_NS_TO_TICKS) ? NS_PER_SEC : rate_reg;
        a_in.side.cmd   = command;
        a_in.side.ok    = (rate_reg != 32'd0) &&
                          ((command == CMD_NS_TO_TICKS) || mono_reg);
        a_in.side.nz    = (operand != 64'd0);
        a_in.side.rate  = rate_reg;
        a_in.side.whole = 64'd0;
        a_in.side.wovf  = 1'b0;
    end

    assign a_v[0] = in_valid;
    assign a_d[0] = a_in;

    genvar gi;
    generate
        for (gi = 0; gi < DIV1_STEPS; gi++)
        begin : g_div1
            tnc_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (adv),
                .in_v  (a_v[gi]),
                .in_d  (a_d[gi]),
                .out_v (a_v[gi+1]),
                .out_d (a_d[gi+1])
            );
        end
    endgenerate

    // partial products: sec * M split in halves, rem * M
    assign mult = (a_d[DIV1_STEPS].side.cmd == CMD_NS_TO_TICKS) ?
                  a_d[DIV1_STEPS].side.rate : NS_PER_SEC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_v_reg <= a_v[DIV1_STEPS];
            c_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg <= a_d[DIV1_STEPS].side;
            m_plo_reg  <= 64'(a_d[DIV1_STEPS].quo[31:0]) * 64'(mult);
            m_phi_reg  <= 64'(a_d[DIV1_STEPS].quo[63:32]) * 64'(mult);
            m_pr_reg   <= 64'(a_d[DIV1_STEPS].rem) * 64'(mult);
        end
    end

    // combine whole part, form the second dividend
    assign wsum = {32'd0, m_plo_reg} + {m_phi_reg, 32'd0};
    assign rsum = m_pr_reg +
                  ((m_side_reg.cmd == CMD_NS_TO_TICKS) ? NS_ROUND_UP : 64'd0);

    always_comb
    begin
        c_next            = '0;
        c_next.side       = m_side_reg;
        c_next.side.whole = wsum[63:0];
        c_next.side.wovf  = |wsum[95:64];
        c_next.rem        = rsum[63:32];
        c_next.num        = {rsum[31:0], 32'd0};
        c_next.quo        = 64'd0;
        c_next.dvs        = (m_side_reg.cmd == CMD_NS_TO_TICKS) ?
                            NS_PER_SEC : m_side_reg.rate;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_d_reg <= c_next;
        end
    end

    assign b_v[0] = c_v_reg;
    assign b_d[0] = c_d_reg;

    generate
        for (gi = 0; gi < DIV2_STEPS; gi++)
        begin : g_div2
            tnc_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (adv),
                .in_v  (b_v[gi]),
                .in_d  (b_d[gi]),
                .out_v (b_v[gi+1]),
                .out_d (b_d[gi+1])
            );
        end
    endgenerate

    // final sum, wrap handling
    assign fsum = {1'b0, b_d[DIV2_STEPS].side.whole} +
                  {33'd0, b_d[DIV2_STEPS].quo[31:0]};

    always_comb
    begin
        fres = fsum[63:0];
        if (b_d[DIV2_STEPS].side.cmd == CMD_NS_TO_TICKS && fres == 64'd0)
        begin
            fres = 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= b_v[DIV2_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (!b_d[DIV2_STEPS].side.ok)
            begin
                ok_reg       <= 1'b0;
                value_reg    <= 64'd0;
                overflow_reg <= 1'b0;
            end
            else if (b_d[DIV2_STEPS].side.cmd == CMD_NS_TO_TICKS &&
                     !b_d[DIV2_STEPS].side.nz)
            begin
                ok_reg       <= 1'b1;
                value_reg    <= 64'd0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                ok_reg       <= 1'b1;
                value_reg    <= fres;
                overflow_reg <= b_d[DIV2_STEPS].side.wovf | fsum[64];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign value     = value_reg;
    assign overflow  = overflow_reg;

    a_in_to_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> a_v[1])
        else $error("accepted transaction did not enter divider");

    a_mul_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (a_v[DIV1_STEPS] && adv) |=> m_v_reg)
        else $error("multiply stage lost a transaction");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (value == 64'd0 && !overflow))
        else $error("failed conversion carries nonzero result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_v[DIV2_STEPS] && !adv) |=> b_v[DIV2_STEPS])
        else $error("divider output dropped during stall");

endmodule
